>>> src/vibrato_detector_defines.svh
// Assertion macros used by the checker file.
`ifndef VIBRATO_DETECTOR_DEFINES_SVH
`define VIBRATO_DETECTOR_DEFINES_SVH

// Property checked only while the block is out of reset.
`define VD_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define VD_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/vd_pkg.sv
package vd_pkg;

  localparam int TIME_W     = 32;
  localparam int RING_DEPTH = 5;
  localparam int RING_IDX_W = $clog2(RING_DEPTH);
  localparam int SMOOTH_W   = 24;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [15:0] ALPHA_RST   = 16'd19661;
  localparam logic [3:0]  MIN_INT_RST = 4'd3;
  localparam logic [3:0]  MAX_INT_RST = 4'd8;
  localparam logic [3:0]  MAX_DEV_RST = 4'd2;
  localparam logic [11:0] MIN_SW_RST  = 12'd26;
  localparam logic [11:0] MAX_SW_RST  = 12'd307;

  typedef enum logic [2:0] {
    CFG_ALPHA         = 3'd0,
    CFG_MIN_INTERVAL  = 3'd1,
    CFG_MAX_INTERVAL  = 3'd2,
    CFG_MAX_DEVIATION = 3'd3,
    CFG_MIN_SWING     = 3'd4,
    CFG_MAX_SWING     = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [3:0]  min_interval;
    logic [3:0]  max_interval;
    logic [3:0]  max_deviation;
    logic [11:0] min_swing;
    logic [11:0] max_swing;
  } cfg_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic                voiced;
    logic [SMOOTH_W-1:0] smooth;
    logic [TIME_W-1:0]   stamp;
  } rec_t;

  function automatic logic [RING_IDX_W-1:0] ring_wrap(input logic [RING_IDX_W:0] v);
    logic [RING_IDX_W:0] lim;
    lim = (RING_IDX_W + 1)'(RING_DEPTH);
    if (v >= lim) begin
      return RING_IDX_W'(v - lim);
    end
    return v[RING_IDX_W-1:0];
  endfunction

endpackage

>>> src/vd_front.sv
module vd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [15:0]   in_pitch,
  input  vd_pkg::cfg_t  cfg,
  input  logic          q_full,
  output logic          push,
  output vd_pkg::rec_t  push_rec
);

  logic [vd_pkg::SMOOTH_W-1:0] smooth_now_r, smooth_now_nxt;
  logic [vd_pkg::TIME_W-1:0]   sample_count_r, sample_count_nxt;
  logic                        voiced;
  logic signed [24:0]          diff;
  logic signed [41:0]          prod;
  logic signed [41:0]          acc;
  logic [vd_pkg::SMOOTH_W-1:0] y0;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign voiced   = (in_pitch != 16'd0);

  // y + alpha*(x - y) with rounding; equal to the weighted mean of x and y.
  assign diff = $signed({1'b0, in_pitch, 8'b0}) - $signed({1'b0, smooth_now_r});
  assign prod = $signed({1'b0, cfg.alpha}) * diff;
  assign acc  = $signed({2'b0, smooth_now_r, 16'b0}) + prod + 42'sd32768;
  assign y0   = acc[39:16];

  always_comb begin
    smooth_now_nxt   = smooth_now_r;
    sample_count_nxt = sample_count_r;
    if (push) begin
      sample_count_nxt = sample_count_r + 1'b1;
      if (voiced) begin
        smooth_now_nxt = y0;
      end
    end
  end

  always_comb begin
    push_rec.voiced = voiced;
    push_rec.smooth = y0;
    push_rec.stamp  = sample_count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_now_r   <= '0;
      sample_count_r <= '0;
    end else begin
      smooth_now_r   <= smooth_now_nxt;
      sample_count_r <= sample_count_nxt;
    end
  end

endmodule

>>> src/vd_queue.sv
module vd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vd_pkg::rec_t  push_rec,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output vd_pkg::rec_t  head
);

  vd_pkg::rec_t                  mem_r [vd_pkg::Q_DEPTH];
  logic [vd_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [vd_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [vd_pkg::Q_CNT_W-1:0]    count_r, count_nxt;

  assign full  = (count_r == vd_pkg::Q_CNT_W'(vd_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == vd_pkg::Q_PTR_W'(vd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == vd_pkg::Q_PTR_W'(vd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

>>> src/vd_back.sv
module vd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  vd_pkg::cfg_t  cfg,
  input  logic          q_empty,
  input  vd_pkg::rec_t  head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [5:0]    out_vibrato_length
);

  localparam int IW = vd_pkg::RING_IDX_W;
  localparam int TW = vd_pkg::TIME_W;
  localparam int SW = vd_pkg::SMOOTH_W;

  // Extremum stage.
  logic [SW-1:0] prev_r, prev_nxt;
  logic [SW-1:0] prev2_r, prev2_nxt;
  logic [TW-1:0] ring_t_r [vd_pkg::RING_DEPTH];
  logic [SW-1:0] ring_p_r [vd_pkg::RING_DEPTH];
  logic [IW-1:0] slot_r, slot_nxt;
  logic          is_ext;
  logic          ring_we;
  logic          a_valid_r, a_valid_nxt;
  logic          a_check_r, a_check_nxt;
  logic [TW-1:0] a_time_r, a_time_nxt;

  // Detection and output stage.
  logic          out_valid_r, out_valid_nxt;
  logic [5:0]    out_len_r, out_len_nxt;
  logic [TW-1:0] last_find_r, last_find_nxt;
  logic          out_adv, a_adv;

  logic [TW-1:0] gap_full [4];
  logic [3:0]    gap [4];
  logic [SW-1:0] swing [4];
  logic [5:0]    g4 [4];
  logic [5:0]    dev [4];
  logic [3:0]    ok;
  logic [3:0]    dev_ok;
  logic [5:0]    total;
  logic          find;
  logic [TW-1:0] elapsed;
  logic [5:0]    len;

  assign out_adv = !out_valid_r || out_ready;
  assign a_adv   = !a_valid_r || out_adv;
  assign pop     = !q_empty && a_adv;

  assign out_valid          = out_valid_r;
  assign out_vibrato_length = out_len_r;

  // prev_r is a strict peak or trough between its neighbors.
  assign is_ext = ((prev_r > head.smooth) && (prev_r > prev2_r)) ||
                  ((prev_r < head.smooth) && (prev_r < prev2_r));
  assign ring_we = pop && head.voiced && is_ext;

  always_comb begin
    prev_nxt    = prev_r;
    prev2_nxt   = prev2_r;
    slot_nxt    = slot_r;
    a_valid_nxt = a_valid_r;
    a_check_nxt = a_check_r;
    a_time_nxt  = a_time_r;
    if (a_adv) begin
      a_valid_nxt = pop;
      a_check_nxt = ring_we;
      a_time_nxt  = head.stamp;
    end
    if (pop && head.voiced) begin
      prev2_nxt = prev_r;
      prev_nxt  = head.smooth;
    end
    if (ring_we) begin
      slot_nxt = vd_pkg::ring_wrap({1'b0, slot_r} + (IW + 1)'(1));
    end
  end

  // The ring already holds the new extremum; slot_r points at the oldest entry.
  always_comb begin
    logic [IW-1:0] ip;
    logic [IW-1:0] ic;
    for (int k = 0; k < 4; k++) begin
      ip          = vd_pkg::ring_wrap({1'b0, slot_r} + (IW + 1)'(k));
      ic          = vd_pkg::ring_wrap({1'b0, slot_r} + (IW + 1)'(k + 1));
      gap_full[k] = ring_t_r[ic] - ring_t_r[ip];
      gap[k]      = gap_full[k][3:0];
      swing[k]    = (ring_p_r[ic] > ring_p_r[ip]) ? ring_p_r[ic] - ring_p_r[ip]
                                                  : ring_p_r[ip] - ring_p_r[ic];
      ok[k]       = (gap_full[k][TW-1:4] == '0) &&
                    (gap[k] >= cfg.min_interval) && (gap[k] <= cfg.max_interval) &&
                    (swing[k] >= {4'b0, cfg.min_swing, 8'b0}) &&
                    (swing[k] <= {4'b0, cfg.max_swing, 8'b0});
    end
    total = {2'b0, gap[0]} + {2'b0, gap[1]} + {2'b0, gap[2]} + {2'b0, gap[3]};
    for (int k = 0; k < 4; k++) begin
      g4[k]     = {gap[k], 2'b0};
      dev[k]    = (g4[k] > total) ? g4[k] - total : total - g4[k];
      dev_ok[k] = (dev[k] <= {cfg.max_deviation, 2'b0});
    end
    find    = a_check_r && (&ok) && (&dev_ok) && (total != '0);
    elapsed = a_time_r - last_find_r;
    len     = '0;
    if (find) begin
      len = (elapsed < {{(TW - 6){1'b0}}, total}) ? elapsed[5:0] : total;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_len_nxt   = out_len_r;
    last_find_nxt = last_find_r;
    if (out_adv) begin
      out_valid_nxt = a_valid_r;
      out_len_nxt   = len;
      if (a_valid_r && find) begin
        last_find_nxt = a_time_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      prev2_r     <= '0;
      slot_r      <= '0;
      a_valid_r   <= 1'b0;
      a_check_r   <= 1'b0;
      out_valid_r <= 1'b0;
      last_find_r <= '0;
      for (int i = 0; i < vd_pkg::RING_DEPTH; i++) begin
        ring_t_r[i] <= '0;
        ring_p_r[i] <= '0;
      end
    end else begin
      prev_r      <= prev_nxt;
      prev2_r     <= prev2_nxt;
      slot_r      <= slot_nxt;
      a_valid_r   <= a_valid_nxt;
      a_check_r   <= a_check_nxt;
      out_valid_r <= out_valid_nxt;
      last_find_r <= last_find_nxt;
      if (ring_we) begin
        ring_t_r[slot_r] <= head.stamp;
        ring_p_r[slot_r] <= prev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_time_r  <= a_time_nxt;
    out_len_r <= out_len_nxt;
  end

endmodule

>>> src/vibrato_detector.sv
// Channel  Ports                               Direction  Moves
// in       in_valid in_ready in_pitch          input      one pitch item
// out      out_valid out_ready out_vibrato_length output  one result item
// cfg      cfg_we cfg_index cfg_wdata          input      one register write
//
// One item is accepted per cycle while the queue is not full; its result passes
// through the queue, the extremum stage and the output register. The smoother
// recursion (one multiply-add) in the front sets the one-item-per-cycle figure.
// Reset is synchronous and active low; the extremum ring is cleared in
// flip-flops at once. A stalled output holds the back stages, and the
// two-entry queue keeps in_ready high until it fills.
module vibrato_detector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_pitch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_vibrato_length,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  vd_pkg::cfg_t cfg_r, cfg_nxt;
  logic         q_full, q_empty, push, pop;
  vd_pkg::rec_t push_rec, head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (vd_pkg::cfg_idx_t'(cfg_index))
        vd_pkg::CFG_ALPHA:         cfg_nxt.alpha         = cfg_wdata;
        vd_pkg::CFG_MIN_INTERVAL:  cfg_nxt.min_interval  = cfg_wdata[3:0];
        vd_pkg::CFG_MAX_INTERVAL:  cfg_nxt.max_interval  = cfg_wdata[3:0];
        vd_pkg::CFG_MAX_DEVIATION: cfg_nxt.max_deviation = cfg_wdata[3:0];
        vd_pkg::CFG_MIN_SWING:     cfg_nxt.min_swing     = cfg_wdata[11:0];
        vd_pkg::CFG_MAX_SWING:     cfg_nxt.max_swing     = cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha         <= vd_pkg::ALPHA_RST;
      cfg_r.min_interval  <= vd_pkg::MIN_INT_RST;
      cfg_r.max_interval  <= vd_pkg::MAX_INT_RST;
      cfg_r.max_deviation <= vd_pkg::MAX_DEV_RST;
      cfg_r.min_swing     <= vd_pkg::MIN_SW_RST;
      cfg_r.max_swing     <= vd_pkg::MAX_SW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  vd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pitch (in_pitch),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  vd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  vd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_empty            (q_empty),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_vibrato_length (out_vibrato_length)
  );

endmodule

>>> src/vd_checker.sv
`include "vibrato_detector_defines.svh"

module vd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_vibrato_length
);

  // A stalled result item must hold.
  `VD_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_vibrato_length), "result changed while stalled")

  // Four gaps of at most fifteen samples bound every span.
  `VD_ASSERT_RUN(a_len_range, out_valid |-> out_vibrato_length <= 6'd60, "span out of range")

  `VD_ASSERT_ANY(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

  `VD_ASSERT_ANY(a_rst_in, !rst_n |=> in_ready, "input not ready after reset")

endmodule

bind vibrato_detector vd_checker u_vd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_vibrato_length (out_vibrato_length)
);
